[hw/rtl/lda_pkg.sv]
// Shared constants and codes for the LDA topic sampler.
package lda_pkg;

    localparam int DOC_W      = 10;
    localparam int WORD_W     = 12;
    localparam int TOPIC_W    = 4;
    localparam int FRAC_BITS  = 16;
    localparam int PRIOR_W    = 24;
    localparam int KREG_W     = 5;
    localparam int VREG_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_BITS = 24;
    localparam int SCORE_BITS = 48;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    localparam logic [PRIOR_W-1:0] ALPHA_RESET  = 24'd6554;
    localparam logic [PRIOR_W-1:0] BETA_RESET   = 24'd6554;
    localparam logic [KREG_W-1:0]  TOPICS_RESET = 5'd10;
    localparam logic [VREG_W-1:0]  VOCAB_RESET  = 13'd4096;

    // item kinds
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_RESAMPLE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_BETA   = 2'd1;
    localparam logic [1:0] REG_TOPICS = 2'd2;
    localparam logic [1:0] REG_VOCAB  = 2'd3;

endpackage

[hw/rtl/lda_if.sv]
// Token request and result request channels of the LDA topic sampler.
interface lda_tok_if import lda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [DOC_W-1:0]   doc_index;
    logic [WORD_W-1:0]  word_index;
    logic [TOPIC_W-1:0] topic_in;
    logic [FRAC_BITS-1:0] random_fraction;

    modport source (output valid, kind, doc_index, word_index, topic_in, random_fraction,
                    input ready);
    modport sink (input valid, kind, doc_index, word_index, topic_in, random_fraction,
                  output ready);
endinterface

interface lda_res_if import lda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TOPIC_W-1:0]  new_topic;
    logic [STATUS_W-1:0] status;

    modport source (output valid, new_topic, status, input ready);
    modport sink (input valid, new_topic, status, output ready);
endinterface

[hw/rtl/lda_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lda_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/lda_score.sv]
// Topic score unit: multi-cycle product and restoring divide, saturated to 48 bits.
module lda_score import lda_pkg::*; #(
    parameter int OP_W  = 37,
    parameter int DIV_W = 41
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [OP_W-1:0]       a,
    input  logic [OP_W-1:0]       b,
    input  logic [DIV_W-1:0]      d,
    output logic                  done,
    output logic [SCORE_BITS-1:0] score
);

    localparam int HW  = (OP_W + 1) / 2;
    localparam int PW  = 2 * OP_W;
    localparam int HIW = PW - SCORE_BITS;
    localparam int CW  = ((HIW > DIV_W) ? HIW : DIV_W) + 1;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_DONE} sc_state_t;

    sc_state_t             state_reg;
    logic [2*HW-1:0]       a_reg, b_reg;
    logic [DIV_W-1:0]      d_reg;
    logic [PW-1:0]         prod_reg;
    logic [5:0]            step_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [SCORE_BITS-1:0] q_reg;
    logic [SCORE_BITS-1:0] lo_reg;

    // partial product for the current quarter
    logic [HW-1:0]   a_half, b_half;
    logic [2*HW-1:0] pp;
    logic [PW-1:0]   prod_next;
    int              shamt;

    always_comb
    begin
        a_half    = step_reg[1] ? a_reg[2*HW-1:HW] : a_reg[HW-1:0];
        b_half    = step_reg[0] ? b_reg[2*HW-1:HW] : b_reg[HW-1:0];
        pp        = (2*HW)'(a_half) * (2*HW)'(b_half);
        shamt     = (int'(step_reg[1]) + int'(step_reg[0])) * HW;
        prod_next = prod_reg + (PW'(pp) << shamt);
    end

    // one quotient bit per cycle
    logic [DIV_W:0]         trial;
    logic                   take;
    logic [HIW-1:0]         prod_hi;

    always_comb
    begin
        trial   = {rem_reg, lo_reg[SCORE_BITS-1]};
        take    = trial >= {1'b0, d_reg};
        prod_hi = prod_reg[PW-1:SCORE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= (2*HW)'(a);
                        b_reg     <= (2*HW)'(b);
                        d_reg     <= d;
                        prod_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= prod_next;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg[1:0] == 2'd3)
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    // zero product, saturation (also zero divisor), or divide
                    if (prod_reg == '0)
                    begin
                        q_reg     <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (CW'(prod_hi) >= CW'(d_reg))
                    begin
                        q_reg     <= SCORE_MAX;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rem_reg   <= DIV_W'(prod_hi);
                        lo_reg    <= prod_reg[SCORE_BITS-1:0];
                        q_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= take ? DIV_W'(trial - {1'b0, d_reg}) : DIV_W'(trial);
                    q_reg    <= {q_reg[SCORE_BITS-2:0], take};
                    lo_reg   <= {lo_reg[SCORE_BITS-2:0], 1'b0};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(SCORE_BITS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done  = (state_reg == S_DONE);
    assign score = q_reg;

endmodule

[hw/rtl/lda_gibbs_topic_sampler.sv]
// LDA collapsed Gibbs sampler: count memories, scoring loop and topic pick.
// Load item: count read, increment, result hand-off. Resample item: count read and decrement,
// then per active topic a count read, multiply, check, divide and hand-off (no divide when the
// score is zero or saturates), then sampling, scan, and increment of the picked topic. One item
// at a time; the next token is taken once the result is in the output register. After reset a
// clearing pass zeroes the count memories; tokens wait until it ends; register writes are taken.
module lda_gibbs_topic_sampler import lda_pkg::*; #(
    parameter int MAX_DOCS   = 1024,
    parameter int MAX_VOCAB  = 4096,
    parameter int MAX_TOPICS = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lda_tok_if.sink     token,
    lda_res_if.source   result
);

    localparam int TB         = $clog2(MAX_TOPICS);
    localparam int KW         = $clog2(MAX_TOPICS + 1);
    localparam int VB         = $clog2(MAX_VOCAB + 1);
    localparam int DOC_DEPTH  = MAX_DOCS * MAX_TOPICS;
    localparam int WORD_DEPTH = MAX_TOPICS * MAX_VOCAB;
    localparam int DAW        = $clog2(DOC_DEPTH);
    localparam int WAW        = $clog2(WORD_DEPTH);
    localparam int CLR_LEN    = (DOC_DEPTH > WORD_DEPTH) ? DOC_DEPTH : WORD_DEPTH;
    localparam int CLW        = $clog2(CLR_LEN);
    localparam int OW         = COUNT_BITS + 17;
    localparam int DW         = ((VB + PRIOR_W > TOTAL_BITS + FRAC_BITS) ?
                                 VB + PRIOR_W : TOTAL_BITS + FRAC_BITS) + 1;
    localparam int VBW        = VB + PRIOR_W;
    localparam int SW         = SCORE_BITS + TB;
    localparam int ACW        = SW + FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_UPD, S_SRD, S_SLAT, S_SWAIT, S_SAMP, S_SCAN, S_DONE
    } state_t;

    // configuration registers
    logic [PRIOR_W-1:0] alpha_reg, beta_reg;
    logic [KREG_W-1:0]  topics_reg;
    logic [VREG_W-1:0]  vocab_reg;

    state_t                state_reg;
    logic [CLW-1:0]        clr_reg;
    logic [DOC_W-1:0]      doc_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic                  dec_phase_reg;
    logic [TB-1:0]         idx_reg;
    logic [KW-1:0]         k_reg;
    logic [DW-1:0]         vb_reg;
    logic                  flag_reg;
    logic [SW-1:0]         sum_reg;
    logic [ACW-1:0]        acc_reg;
    logic [3:0]            bit_reg;
    logic [SW-1:0]         cum_reg;
    logic [TB-1:0]         res_topic_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [TOPIC_W-1:0]    out_topic_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [TOTAL_BITS-1:0] total_reg [MAX_TOPICS];
    logic [SCORE_BITS-1:0] score_reg [MAX_TOPICS];

    // APB register port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_RESET;
            beta_reg   <= BETA_RESET;
            topics_reg <= TOPICS_RESET;
            vocab_reg  <= VOCAB_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ALPHA:  alpha_reg  <= pwdata[PRIOR_W-1:0];
                REG_BETA:   beta_reg   <= pwdata[PRIOR_W-1:0];
                REG_TOPICS: topics_reg <= pwdata[KREG_W-1:0];
                REG_VOCAB:  vocab_reg  <= pwdata[VREG_W-1:0];
                default:    alpha_reg  <= alpha_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ALPHA:  prdata = 32'(alpha_reg);
            REG_BETA:   prdata = 32'(beta_reg);
            REG_TOPICS: prdata = 32'(topics_reg);
            REG_VOCAB:  prdata = 32'(vocab_reg);
            default:    prdata = '0;
        endcase
    end

    // clamped topic count and vocabulary size
    logic [KW-1:0] k_clamp;
    logic [VB-1:0] v_clamp;
    logic          bad_index;

    always_comb
    begin
        if (topics_reg == '0)
            k_clamp = KW'(1);
        else if (32'(topics_reg) > MAX_TOPICS)
            k_clamp = KW'(MAX_TOPICS);
        else
            k_clamp = KW'(topics_reg);
        if (vocab_reg == '0)
            v_clamp = VB'(1);
        else if (32'(vocab_reg) > MAX_VOCAB)
            v_clamp = VB'(MAX_VOCAB);
        else
            v_clamp = VB'(vocab_reg);
        bad_index = (32'(token.doc_index) >= MAX_DOCS) ||
                    (32'(token.word_index) >= MAX_VOCAB) ||
                    (32'(token.topic_in) >= 32'(k_clamp));
    end

    // count memory addresses for the current topic
    logic [DAW-1:0] doc_addr;
    logic [WAW-1:0] word_addr;
    assign doc_addr  = DAW'(32'(doc_reg) * MAX_TOPICS + 32'(idx_reg));
    assign word_addr = WAW'(32'(idx_reg) * MAX_VOCAB + 32'(word_reg));

    logic                  clearing, mem_re;
    logic [COUNT_BITS-1:0] doc_rdata, word_rdata;
    logic [COUNT_BITS-1:0] doc_new, word_new;
    logic [TOTAL_BITS-1:0] total_cur, total_new;
    logic                  bump_flag;

    assign clearing = (state_reg == S_CLEAR);
    assign mem_re   = (state_reg == S_RD) || (state_reg == S_SRD);
    assign total_cur = total_reg[idx_reg];

    // saturating increment or decrement of the three counts
    always_comb
    begin
        bump_flag = 1'b0;
        if (!dec_phase_reg)
        begin
            if (doc_rdata == COUNT_MAX) begin doc_new = doc_rdata; bump_flag = 1'b1; end
            else doc_new = doc_rdata + 1'b1;
            if (word_rdata == COUNT_MAX) begin word_new = word_rdata; bump_flag = 1'b1; end
            else word_new = word_rdata + 1'b1;
            if (total_cur == TOTAL_MAX) begin total_new = total_cur; bump_flag = 1'b1; end
            else total_new = total_cur + 1'b1;
        end
        else
        begin
            if (doc_rdata == '0) begin doc_new = doc_rdata; bump_flag = 1'b1; end
            else doc_new = doc_rdata - 1'b1;
            if (word_rdata == '0) begin word_new = word_rdata; bump_flag = 1'b1; end
            else word_new = word_rdata - 1'b1;
            if (total_cur == '0) begin total_new = total_cur; bump_flag = 1'b1; end
            else total_new = total_cur - 1'b1;
        end
    end

    lda_ram #(.WIDTH(COUNT_BITS), .DEPTH(DOC_DEPTH)) u_doc_ram (
        .clk   (clk),
        .we    (clearing ? (32'(clr_reg) < DOC_DEPTH) : (state_reg == S_UPD)),
        .waddr (clearing ? DAW'(clr_reg) : doc_addr),
        .wdata (clearing ? '0 : doc_new),
        .re    (mem_re),
        .raddr (doc_addr),
        .rdata (doc_rdata)
    );

    lda_ram #(.WIDTH(COUNT_BITS), .DEPTH(WORD_DEPTH)) u_word_ram (
        .clk   (clk),
        .we    (clearing ? (32'(clr_reg) < WORD_DEPTH) : (state_reg == S_UPD)),
        .waddr (clearing ? WAW'(clr_reg) : word_addr),
        .wdata (clearing ? '0 : word_new),
        .re    (mem_re),
        .raddr (word_addr),
        .rdata (word_rdata)
    );

    // score operands from the freshly read counts
    logic [OW-1:0]         op_a, op_b;
    logic [DW-1:0]         op_d;
    logic                  sc_done;
    logic [SCORE_BITS-1:0] sc_score;

    assign op_a = (OW'(doc_rdata) << FRAC_BITS) + OW'(alpha_reg);
    assign op_b = (OW'(word_rdata) << FRAC_BITS) + OW'(beta_reg);
    assign op_d = (DW'(total_cur) << FRAC_BITS) + vb_reg;

    lda_score #(.OP_W(OW), .DIV_W(DW)) u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_SLAT),
        .a     (op_a),
        .b     (op_b),
        .d     (op_d),
        .done  (sc_done),
        .score (sc_score)
    );

    // scan helpers
    logic [SW-1:0] cum_next, sample;
    logic          last_topic;
    assign cum_next   = cum_reg + SW'(score_reg[idx_reg]);
    assign sample     = acc_reg[ACW-1:FRAC_BITS];
    assign last_topic = (32'(idx_reg) + 1 == 32'(k_reg));

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            dec_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TOPICS; i++)
            begin
                total_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && result.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLW'(CLR_LEN - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (token.valid)
                    begin
                        doc_reg  <= token.doc_index;
                        word_reg <= token.word_index;
                        frac_reg <= token.random_fraction;
                        k_reg    <= k_clamp;
                        vb_reg   <= DW'(VBW'(v_clamp) * VBW'(beta_reg));
                        flag_reg <= 1'b0;
                        if (bad_index)
                        begin
                            res_topic_reg  <= '0;
                            res_status_reg <= ST_RANGE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            idx_reg       <= TB'(token.topic_in);
                            dec_phase_reg <= (token.kind == KIND_RESAMPLE);
                            state_reg     <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    total_reg[idx_reg] <= total_new;
                    flag_reg           <= flag_reg | bump_flag;
                    if (dec_phase_reg)
                    begin
                        dec_phase_reg <= 1'b0;
                        idx_reg       <= '0;
                        sum_reg       <= '0;
                        state_reg     <= S_SRD;
                    end
                    else
                    begin
                        res_topic_reg  <= idx_reg;
                        res_status_reg <= (flag_reg | bump_flag) ? ST_SAT : ST_OK;
                        state_reg      <= S_DONE;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SLAT;
                end
                S_SLAT:
                begin
                    state_reg <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (sc_done)
                    begin
                        score_reg[idx_reg] <= sc_score;
                        sum_reg            <= sum_reg + SW'(sc_score);
                        if (last_topic)
                        begin
                            acc_reg   <= '0;
                            bit_reg   <= 4'd15;
                            state_reg <= S_SAMP;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_SAMP:
                begin
                    // sum * fraction, one fraction bit per cycle, MSB first
                    acc_reg <= (acc_reg << 1) + (frac_reg[bit_reg] ? ACW'(sum_reg) : '0);
                    if (bit_reg == 4'd0)
                    begin
                        idx_reg   <= '0;
                        cum_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 4'd1;
                    end
                end
                S_SCAN:
                begin
                    // first topic whose running score reaches the sample, else the last
                    if ((cum_next >= sample) || last_topic)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        cum_reg <= cum_next;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_topic_reg  <= TOPIC_W'(res_topic_reg);
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign token.ready      = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.new_topic = out_topic_reg;
    assign result.status    = out_status_reg;

`ifndef SYNTH
    // one token in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (token.valid && token.ready) |=> !token.ready)
        else $error("token accepted while busy");

    // range errors report topic zero
    a_range_topic: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_RANGE) |-> (result.new_topic == '0))
        else $error("range error with nonzero topic");

    // scan never runs past the active topics
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(idx_reg) < 32'(k_reg)))
        else $error("scan index beyond active topics");

    // score unit only finishes while the sequencer waits for it
    a_score_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sc_done |-> (state_reg == S_SWAIT))
        else $error("score done outside wait state");
`endif

endmodule
